// File: hdl/c3x3_pkg.sv
// Shared types, constants and helper functions for the 3x3 convolution core.
// Used by every module of the block but c3x3_ram; depends on nothing else.
`timescale 1ns / 1ps

package c3x3_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int HEIGHT_LIMIT = 4096;
  localparam int COEF_BITS = 8;
  localparam int PIX_BITS = 8;

  localparam int COL_BITS = $clog2(MAX_WIDTH);
  localparam int WEFF_BITS = COL_BITS + 1;
  localparam int ROW_BITS = $clog2(HEIGHT_LIMIT + 2);
  localparam int PROD_BITS = COEF_BITS + PIX_BITS;
  localparam int SUM_BITS = PROD_BITS + 4;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS = 24;
  localparam int SHIFT_BITS = 4;
  localparam int WIDTH_REG_BITS = 11;
  localparam int HEIGHT_REG_BITS = 13;

  localparam logic [CFG_DATA_BITS-1:0] COEF_TOP_RESET = CFG_DATA_BITS'(0);
  localparam logic [CFG_DATA_BITS-1:0] COEF_MID_RESET = CFG_DATA_BITS'(256);
  localparam logic [CFG_DATA_BITS-1:0] COEF_BOT_RESET = CFG_DATA_BITS'(0);
  localparam logic [WIDTH_REG_BITS-1:0] WIDTH_RESET = WIDTH_REG_BITS'(1024);
  localparam logic [HEIGHT_REG_BITS-1:0] HEIGHT_RESET = HEIGHT_REG_BITS'(4096);

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  localparam logic [PIX_BITS-1:0] PIX_MAX = '1;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_COEF_TOP,
    REG_COEF_MID,
    REG_COEF_BOT,
    REG_NORM_SHIFT,
    REG_FRAME_WIDTH,
    REG_FRAME_HEIGHT
  } cfg_reg_t;

  typedef struct packed {
    logic                kind;
    logic [PIX_BITS-1:0] pixel;
  } in_beat_t;

  typedef struct packed {
    logic [PIX_BITS-1:0] filtered;
    logic                end_of_frame;
  } out_beat_t;

  // Which neighbors of an output position lie inside the frame, and whether it is the last of the frame.
  typedef struct packed {
    logic top_ok;
    logic bot_ok;
    logic left_ok;
    logic right_ok;
    logic last;
  } pos_t;

  // One accepted beat on its way from the counters to the window.
  typedef struct packed {
    logic [COL_BITS-1:0] col;
    logic                wr;
    logic [PIX_BITS-1:0] bot;
    logic                emit;
    pos_t                pos;
  } step_t;

  typedef logic [8:0][PIX_BITS-1:0] win_t;

  function automatic logic signed [COEF_BITS-1:0] coef_at(
      input logic [CFG_DATA_BITS-1:0] row, input int k);
    logic [CFG_DATA_BITS+3*COEF_BITS-1:0] ext;
    ext = {{(3 * COEF_BITS){1'b0}}, row};
    return ext[k*COEF_BITS +: COEF_BITS];
  endfunction

endpackage

// File: hdl/c3x3_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; used for the two line stores.
`timescale 1ns / 1ps

module c3x3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int ADDR_BITS = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic                 re,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/c3x3_front.sv
// Input side: frame position counters, drain handling and the first stage register.
// Depends on c3x3_pkg.
`timescale 1ns / 1ps

module c3x3_front (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  input  c3x3_pkg::in_beat_t                     in_data,
  output logic                                   in_stall,
  input  logic [c3x3_pkg::WIDTH_REG_BITS-1:0]    frame_width,
  input  logic [c3x3_pkg::HEIGHT_REG_BITS-1:0]   frame_height,
  input  logic                                   b_go,
  output logic                                   b_valid,
  output c3x3_pkg::step_t                        b_job,
  output logic                                   accept,
  output logic [c3x3_pkg::COL_BITS-1:0]          rd_col
);

  localparam int CB = c3x3_pkg::COL_BITS;
  localparam int WB = c3x3_pkg::WEFF_BITS;
  localparam int RB = c3x3_pkg::ROW_BITS;

  logic [CB-1:0] in_column, out_column;
  logic [RB-1:0] in_row, out_row;

  logic [WB-1:0] weff;
  logic [RB-1:0] heff;
  logic [CB-1:0] col_now, ocol_now;
  logic [WB-1:0] col_inc, ocol_inc;
  logic          wrap, owrap, taking, ignored, emit, b_rdy;
  logic [RB:0]   orow_inc;
  c3x3_pkg::pos_t pos;

  always_comb begin
    if (frame_width == '0) begin
      weff = WB'(1);
    end else if (int'(frame_width) > c3x3_pkg::MAX_WIDTH) begin
      weff = WB'(c3x3_pkg::MAX_WIDTH);
    end else begin
      weff = WB'(frame_width);
    end
    if (frame_height == '0) begin
      heff = RB'(1);
    end else if (int'(frame_height) > c3x3_pkg::HEIGHT_LIMIT) begin
      heff = RB'(c3x3_pkg::HEIGHT_LIMIT);
    end else begin
      heff = RB'(frame_height);
    end

    col_now = ({1'b0, in_column} >= weff) ? '0 : in_column;
    ocol_now = ({1'b0, out_column} >= weff) ? '0 : out_column;
    col_inc = {1'b0, col_now} + WB'(1);
    ocol_inc = {1'b0, ocol_now} + WB'(1);
    wrap = col_inc >= weff;
    owrap = ocol_inc >= weff;
    orow_inc = {1'b0, out_row} + (RB + 1)'(1);

    taking = in_row < heff;
    ignored = taking && (in_data.kind == c3x3_pkg::KIND_DRAIN);
    emit = (in_row >= RB'(2)) || ((in_row == RB'(1)) && (col_now != '0));

    pos.top_ok = out_row != '0;
    pos.bot_ok = orow_inc < {1'b0, heff};
    pos.left_ok = ocol_now != '0;
    pos.right_ok = ocol_inc < weff;
    pos.last = !pos.bot_ok && !pos.right_ok;
  end

  assign b_rdy = !b_valid || b_go;
  assign in_stall = !b_rdy;
  assign accept = in_valid && b_rdy;
  assign rd_col = col_now;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_column <= '0;
      in_row <= '0;
      out_column <= '0;
      out_row <= '0;
      b_valid <= 1'b0;
    end else begin
      if (b_rdy) begin
        b_valid <= accept && !ignored;
      end
      if (accept) begin
        if (ignored) begin
          in_column <= col_now;
          out_column <= ocol_now;
        end else if (emit && pos.last) begin
          in_column <= '0;
          in_row <= '0;
          out_column <= '0;
          out_row <= '0;
        end else begin
          in_column <= wrap ? '0 : col_inc[CB-1:0];
          if (wrap) begin
            in_row <= in_row + RB'(1);
          end
          if (emit) begin
            out_column <= owrap ? '0 : ocol_inc[CB-1:0];
            if (owrap) begin
              out_row <= orow_inc[RB-1:0];
            end
          end else begin
            out_column <= ocol_now;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && b_rdy) begin
      b_job.col <= col_now;
      b_job.wr <= taking;
      b_job.bot <= taking ? in_data.pixel : '0;
      b_job.emit <= emit;
      b_job.pos <= pos;
    end
  end

endmodule

// File: hdl/c3x3_window.sv
// Line stores and the 3x3 pixel window, with forwarding for a read that meets
// a write to the same column. Depends on c3x3_pkg and c3x3_ram.
`timescale 1ns / 1ps

module c3x3_window (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic [c3x3_pkg::COL_BITS-1:0] rd_col,
  input  logic                          b_valid,
  input  c3x3_pkg::step_t               b_job,
  output logic                          b_go,
  input  logic                          c_rdy,
  output logic                          c_valid,
  output c3x3_pkg::pos_t                c_pos,
  output c3x3_pkg::win_t                win
);

  localparam int PB = c3x3_pkg::PIX_BITS;

  logic [PB-1:0] upper_q, lower_q, top_cur, mid_cur;
  logic [PB-1:0] fwd_upper, fwd_lower;
  logic          fwd_hit, ram_we;
  c3x3_pkg::win_t win_next;

  assign ram_we = b_go && b_job.wr;

  c3x3_ram #(
    .WIDTH(c3x3_pkg::PIX_BITS),
    .DEPTH(c3x3_pkg::MAX_WIDTH)
  ) u_upper (
    .clk(clk),
    .we(ram_we),
    .waddr(b_job.col),
    .wdata(mid_cur),
    .re(accept),
    .raddr(rd_col),
    .rdata(upper_q)
  );

  c3x3_ram #(
    .WIDTH(c3x3_pkg::PIX_BITS),
    .DEPTH(c3x3_pkg::MAX_WIDTH)
  ) u_lower (
    .clk(clk),
    .we(ram_we),
    .waddr(b_job.col),
    .wdata(b_job.bot),
    .re(accept),
    .raddr(rd_col),
    .rdata(lower_q)
  );

  assign top_cur = fwd_hit ? fwd_upper : upper_q;
  assign mid_cur = fwd_hit ? fwd_lower : lower_q;
  assign b_go = b_valid && (!c_valid || c_rdy);

  always_comb begin
    win_next = win;
    for (int r = 0; r < 3; r++) begin
      win_next[r*3] = win[r*3+1];
      win_next[r*3+1] = win[r*3+2];
    end
    win_next[2] = top_cur;
    win_next[5] = mid_cur;
    win_next[8] = b_job.bot;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
      c_valid <= 1'b0;
      win <= '0;
    end else begin
      if (accept) begin
        fwd_hit <= ram_we && (b_job.col == rd_col);
      end
      if (b_go) begin
        win <= win_next;
      end
      if (!c_valid || c_rdy) begin
        c_valid <= b_go && b_job.emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fwd_upper <= mid_cur;
      fwd_lower <= b_job.bot;
    end
    if (!c_valid || c_rdy) begin
      c_pos <= b_job.pos;
    end
  end

endmodule

// File: hdl/c3x3_mac.sv
// Weighting, summation, rounding and clamping of one window, ending in the
// output register. Depends on c3x3_pkg.
`timescale 1ns / 1ps

module c3x3_mac (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic [c3x3_pkg::CFG_DATA_BITS-1:0]   coef_top_row,
  input  logic [c3x3_pkg::CFG_DATA_BITS-1:0]   coef_middle_row,
  input  logic [c3x3_pkg::CFG_DATA_BITS-1:0]   coef_bottom_row,
  input  logic [c3x3_pkg::SHIFT_BITS-1:0]      norm_shift,
  input  logic                                 c_valid,
  input  c3x3_pkg::pos_t                       c_pos,
  input  c3x3_pkg::win_t                       win,
  output logic                                 c_rdy,
  output logic                                 out_valid,
  output c3x3_pkg::out_beat_t                  out_data,
  input  logic                                 out_stall
);

  localparam int PB = c3x3_pkg::PIX_BITS;
  localparam int QB = c3x3_pkg::PROD_BITS;
  localparam int SB = c3x3_pkg::SUM_BITS;

  logic signed [QB-1:0] prod [9];
  logic signed [QB-1:0] prod_next [9];
  logic signed [SB-1:0] sum, sum_next;
  logic signed [SB-1:0] row_sum [3];
  logic                 d_valid, d_last, e_valid, e_last;
  logic                 out_rdy, e_rdy, d_rdy;
  logic [SB:0]          half, rnd, shifted;
  logic [PB-1:0]        filt;

  assign out_rdy = !out_valid || !out_stall;
  assign e_rdy = !e_valid || out_rdy;
  assign d_rdy = !d_valid || e_rdy;
  assign c_rdy = d_rdy;

  always_comb begin
    logic [c3x3_pkg::CFG_DATA_BITS-1:0] rows [3];
    logic signed [QB:0] full;
    logic               use_term;
    rows[0] = coef_top_row;
    rows[1] = coef_middle_row;
    rows[2] = coef_bottom_row;
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        use_term = (r != 0 || c_pos.top_ok) && (r != 2 || c_pos.bot_ok) &&
                   (k != 0 || c_pos.left_ok) && (k != 2 || c_pos.right_ok);
        full = (QB + 1)'(c3x3_pkg::coef_at(rows[r], k)) *
               (QB + 1)'($signed({1'b0, win[r*3+k]}));
        prod_next[r*3+k] = use_term ? full[QB-1:0] : '0;
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      row_sum[r] = SB'(prod[r*3]) + SB'(prod[r*3+1]) + SB'(prod[r*3+2]);
    end
    sum_next = row_sum[0] + row_sum[1] + row_sum[2];
  end

  always_comb begin
    half = (norm_shift == '0) ? '0 : ((SB + 1)'(1) << (norm_shift - 1'b1));
    rnd = {1'b0, sum} + half;
    shifted = rnd >> norm_shift;
    if (sum[SB-1] || sum == '0) begin
      filt = '0;
    end else if (shifted > (SB + 1)'(c3x3_pkg::PIX_MAX)) begin
      filt = c3x3_pkg::PIX_MAX;
    end else begin
      filt = shifted[PB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
      e_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (d_rdy) begin
        d_valid <= c_valid;
      end
      if (e_rdy) begin
        e_valid <= d_valid;
      end
      if (out_rdy) begin
        out_valid <= e_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (d_rdy) begin
      prod <= prod_next;
      d_last <= c_pos.last;
    end
    if (e_rdy) begin
      sum <= sum_next;
      e_last <= d_last;
    end
    if (out_rdy) begin
      out_data.filtered <= filt;
      out_data.end_of_frame <= e_last;
    end
  end

endmodule

// File: hdl/conv3x3_zero_pad_clamp_core.sv
// Top level of the zero-padded 3x3 convolution core with rounding and clamping.
// Depends on c3x3_pkg, c3x3_front, c3x3_window and c3x3_mac.
`timescale 1ns / 1ps

// The core takes one beat per clock and gives back one filtered pixel per clock
// once the window is primed, while no stall holds the flow. A result passes the
// line store read, made at the edge that accepts the input beat completing its
// window, then the window register and three arithmetic stages before it is
// presented on the output. Results trail the input by
// one row and one pixel, so after the last pixel of a frame frame_width + 1
// drain beats flush the rest of it; end_of_frame marks the last pixel. The
// line stores need no clearing after reset, and the core is ready in the first
// cycle after reset. Registers may be written only while no beat is in flight.

module conv3x3_zero_pad_clamp_core (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  input  c3x3_pkg::in_beat_t                    in_data,
  output logic                                  in_stall,
  output logic                                  out_valid,
  output c3x3_pkg::out_beat_t                   out_data,
  input  logic                                  out_stall,
  input  logic                                  cfg_we,
  input  logic [c3x3_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [c3x3_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  logic [c3x3_pkg::CFG_DATA_BITS-1:0]   coef_top_row, coef_middle_row, coef_bottom_row;
  logic [c3x3_pkg::SHIFT_BITS-1:0]      norm_shift;
  logic [c3x3_pkg::WIDTH_REG_BITS-1:0]  frame_width;
  logic [c3x3_pkg::HEIGHT_REG_BITS-1:0] frame_height;

  logic                          accept, b_valid, b_go, c_valid, c_rdy;
  logic [c3x3_pkg::COL_BITS-1:0] rd_col;
  c3x3_pkg::step_t               b_job;
  c3x3_pkg::pos_t                c_pos;
  c3x3_pkg::win_t                win;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_top_row <= c3x3_pkg::COEF_TOP_RESET;
      coef_middle_row <= c3x3_pkg::COEF_MID_RESET;
      coef_bottom_row <= c3x3_pkg::COEF_BOT_RESET;
      norm_shift <= '0;
      frame_width <= c3x3_pkg::WIDTH_RESET;
      frame_height <= c3x3_pkg::HEIGHT_RESET;
    end else if (cfg_we) begin
      case (c3x3_pkg::cfg_reg_t'(cfg_index))
        c3x3_pkg::REG_COEF_TOP: coef_top_row <= cfg_data;
        c3x3_pkg::REG_COEF_MID: coef_middle_row <= cfg_data;
        c3x3_pkg::REG_COEF_BOT: coef_bottom_row <= cfg_data;
        c3x3_pkg::REG_NORM_SHIFT: norm_shift <= cfg_data[c3x3_pkg::SHIFT_BITS-1:0];
        c3x3_pkg::REG_FRAME_WIDTH: frame_width <= cfg_data[c3x3_pkg::WIDTH_REG_BITS-1:0];
        c3x3_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data[c3x3_pkg::HEIGHT_REG_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  c3x3_front u_front (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_data(in_data),
    .in_stall(in_stall),
    .frame_width(frame_width),
    .frame_height(frame_height),
    .b_go(b_go),
    .b_valid(b_valid),
    .b_job(b_job),
    .accept(accept),
    .rd_col(rd_col)
  );

  c3x3_window u_window (
    .clk(clk),
    .rst(rst),
    .accept(accept),
    .rd_col(rd_col),
    .b_valid(b_valid),
    .b_job(b_job),
    .b_go(b_go),
    .c_rdy(c_rdy),
    .c_valid(c_valid),
    .c_pos(c_pos),
    .win(win)
  );

  c3x3_mac u_mac (
    .clk(clk),
    .rst(rst),
    .coef_top_row(coef_top_row),
    .coef_middle_row(coef_middle_row),
    .coef_bottom_row(coef_bottom_row),
    .norm_shift(norm_shift),
    .c_valid(c_valid),
    .c_pos(c_pos),
    .win(win),
    .c_rdy(c_rdy),
    .out_valid(out_valid),
    .out_data(out_data),
    .out_stall(out_stall)
  );

endmodule
